// ===== hdl/llq_pkg.sv =====
`timescale 1ns / 1ps
package llq_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TIME_W          = 16;
  localparam int TAG_W           = 16;
  localparam int QSEL_W          = 3;
  localparam int ENTRY_W         = TAG_W + TIME_W;
  localparam logic [TIME_W-1:0] LIMIT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    CMD_PUSH_LEAST = 2'd0,
    CMD_PUSH_NAMED = 2'd1,
    CMD_TICK       = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LIMIT    = 2'd1,
    ST_NO_QUEUE = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef struct packed {
    logic load_in;
    logic scan_step;
    logic push_do;
    logic tick_dec;
    logic rd_head;
    logic pop;
    logic rd_next;
    logic load_head;
    logic done_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       out_free;
    logic       q_busy;
    logic       q_done;
    logic       q_more;
  } dp_sts_t;

endpackage

// ===== hdl/llq_in_if.sv =====
`timescale 1ns / 1ps
interface llq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  queue_sel;
  logic [15:0] job_time;
  logic [15:0] job_tag;

  modport source (output valid, cmd, queue_sel, job_time, job_tag, input ready);
  modport sink   (input valid, cmd, queue_sel, job_time, job_tag, output ready);
endinterface

// ===== hdl/llq_out_if.sv =====
`timescale 1ns / 1ps
interface llq_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [2:0]  queue_index;
  logic [15:0] done_tag;
  logic [15:0] done_time;
  logic        last;

  modport source (output valid, kind, status, queue_index, done_tag, done_time, last,
                  input ready);
  modport sink   (input valid, kind, status, queue_index, done_tag, done_time, last,
                  output ready);
endinterface

// ===== hdl/least_loaded_job_queues.sv =====
// least loaded job queues
// req_i carries commands: push to the least loaded queue, push to a named
// queue, or tick. rsp_o returns results: one push response per push, and
// one completion per finished head job on a tick, in ascending queue order,
// with last set on the final result of the item. cfg_we_i/cfg_wdata_i write
// the load limit; users must do so only while the block is idle (unchecked).
// one item at a time: req_i.ready is high only while idle.
// named push: straight to the push step; least-loaded push: first the
// scan of the loads, one queue per cycle, then the push step.
// tick: queues are checked in turn; a finished job is read from the job
// store (one read port) and emitted, then a next head is loaded if any.
// results wait in an output register; a stalled receiver holds the block
// in its current step, and nothing is lost.
// reset clears loads, counters and pointers and sets the limit to 1000;
// the job store needs no clearing.
`timescale 1ns / 1ps
module least_loaded_job_queues import llq_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  llq_in_if.sink            req_i,
  llq_out_if.source         rsp_o
);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [QW-1:0] qidx;

  llq_ctrl #(.NUM_QUEUES(NUM_QUEUES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .qidx_o     (qidx)
  );

  llq_dp #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .cmd_i       (cmd),
    .qidx_i      (qidx),
    .sts_o       (sts)
  );
endmodule

// ===== hdl/llq_ram.sv =====
`timescale 1ns / 1ps
module llq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/llq_ctrl.sv =====
`timescale 1ns / 1ps
module llq_ctrl import llq_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dp_sts_t       sts_i,
  output dp_cmd_t       cmd_o,
  output logic [QW-1:0] qidx_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PUSH, S_TCHK, S_TEMIT, S_TLOAD
  } state_e;

  state_e        state_q;
  logic [QW-1:0] qidx_q;
  logic          last_q;

  assign last_q = (qidx_q == QW'(NUM_QUEUES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      qidx_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          qidx_q <= '0;
          if (in_valid_i) begin
            unique case (sts_i.in_cmd)
              CMD_PUSH_LEAST: state_q <= S_SCAN;
              CMD_PUSH_NAMED: state_q <= S_PUSH;
              CMD_TICK:       state_q <= S_TCHK;
              default:        state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (last_q) begin
            state_q <= S_PUSH;
          end else begin
            qidx_q <= qidx_q + 1'b1;
          end
        end
        S_PUSH: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        S_TCHK: begin
          if (sts_i.q_busy && sts_i.q_done) begin
            state_q <= S_TEMIT;
          end else if (last_q) begin
            state_q <= S_IDLE;
          end else begin
            qidx_q <= qidx_q + 1'b1;
          end
        end
        S_TEMIT: begin
          if (sts_i.out_free) begin
            if (sts_i.q_more) begin
              state_q <= S_TLOAD;
            end else if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              qidx_q  <= qidx_q + 1'b1;
              state_q <= S_TCHK;
            end
          end
        end
        S_TLOAD: begin
          if (last_q) begin
            state_q <= S_IDLE;
          end else begin
            qidx_q  <= qidx_q + 1'b1;
            state_q <= S_TCHK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan_step = (state_q == S_SCAN);
    cmd_o.push_do   = (state_q == S_PUSH) && sts_i.out_free;
    cmd_o.tick_dec  = (state_q == S_TCHK) && sts_i.q_busy;
    cmd_o.rd_head   = (state_q == S_TCHK) && sts_i.q_busy && sts_i.q_done;
    cmd_o.done_emit = (state_q == S_TEMIT) && sts_i.out_free;
    cmd_o.pop       = cmd_o.done_emit;
    cmd_o.rd_next   = cmd_o.done_emit && sts_i.q_more;
    cmd_o.load_head = (state_q == S_TLOAD);
  end

  assign qidx_o = qidx_q;
endmodule

// ===== hdl/llq_dp.sv =====
`timescale 1ns / 1ps
module llq_dp import llq_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int SD = NUM_QUEUES * QUEUE_DEPTH,
  localparam int AW = $clog2(SD)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TIME_W-1:0]  cfg_wdata_i,
  llq_in_if.sink             req,
  llq_out_if.source          rsp,
  input  dp_cmd_t            cmd_i,
  input  logic [QW-1:0]      qidx_i,
  output dp_sts_t            sts_o
);
  logic [TIME_W-1:0] limit_q;
  logic [TIME_W-1:0] load_q [NUM_QUEUES];
  logic [TIME_W-1:0] head_q [NUM_QUEUES];
  logic [PW-1:0]     rp_q   [NUM_QUEUES];
  logic [PW-1:0]     wp_q   [NUM_QUEUES];
  logic [CW-1:0]     cnt_q  [NUM_QUEUES];

  logic [TIME_W-1:0] jt_q, best_q;
  logic [TAG_W-1:0]  tag_q;
  logic [QSEL_W-1:0] tq_q;
  logic              found_q;

  logic              out_valid_q, out_kind_q, out_last_q;
  logic [1:0]        out_status_q;
  logic [QSEL_W-1:0] out_qi_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [TIME_W-1:0] out_time_q;

  logic [QW-1:0]     qsel;
  logic [TIME_W:0]   sum;
  status_e           push_st;
  logic              ram_we, ram_re;
  logic [AW-1:0]     waddr, raddr, base_a, base_q;
  logic [ENTRY_W-1:0] rdata;
  logic [PW-1:0]     rp_nxt, wp_nxt;
  logic              later;
  logic [TIME_W-1:0] scan_ld;

  assign qsel   = tq_q[QW-1:0];
  assign base_q = AW'(qsel) * AW'(QUEUE_DEPTH);
  assign base_a = AW'(qidx_i) * AW'(QUEUE_DEPTH);
  assign rp_nxt = (rp_q[qidx_i] == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q[qidx_i] + 1'b1;
  assign wp_nxt = (wp_q[qsel] == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q[qsel] + 1'b1;
  assign sum    = {1'b0, load_q[qsel]} + {1'b0, jt_q};
  assign scan_ld = load_q[qidx_i];

  always_comb begin
    if (!found_q)                               push_st = ST_NO_QUEUE;
    else if (sum >= {1'b0, limit_q})            push_st = ST_LIMIT;
    else if (cnt_q[qsel] >= CW'(QUEUE_DEPTH))   push_st = ST_FULL;
    else                                        push_st = ST_OK;
  end

  always_comb begin
    later = 1'b0;
    for (int b = 0; b < NUM_QUEUES; b++) begin
      if (b > int'(qidx_i) && cnt_q[b] != '0 && head_q[b] <= TIME_W'(1)) later = 1'b1;
    end
  end

  assign ram_we = cmd_i.push_do && (push_st == ST_OK);
  assign waddr  = base_q + AW'(wp_q[qsel]);
  assign ram_re = cmd_i.rd_head || cmd_i.rd_next;
  assign raddr  = base_a + AW'(cmd_i.rd_next ? rp_nxt : rp_q[qidx_i]);

  llq_ram #(.WIDTH(ENTRY_W), .DEPTH(SD)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({tag_q, jt_q}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        load_q[i] <= '0;
        head_q[i] <= '0;
        rp_q[i]   <= '0;
        wp_q[i]   <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.push_do || cmd_i.done_emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_in) begin
        found_q <= (req.cmd == CMD_PUSH_NAMED) && ({1'b0, req.queue_sel} < 4'(NUM_QUEUES));
      end else if (cmd_i.scan_step && scan_ld < limit_q && (!found_q || scan_ld <= best_q)) begin
        found_q <= 1'b1;
      end
      if (ram_we) begin
        if (cnt_q[qsel] == '0) head_q[qsel] <= jt_q;
        wp_q[qsel]   <= wp_nxt;
        cnt_q[qsel]  <= cnt_q[qsel] + 1'b1;
        load_q[qsel] <= sum[TIME_W-1:0];
      end
      if (cmd_i.tick_dec && head_q[qidx_i] != '0) begin
        head_q[qidx_i] <= head_q[qidx_i] - 1'b1;
        if (load_q[qidx_i] != '0) load_q[qidx_i] <= load_q[qidx_i] - 1'b1;
      end
      if (cmd_i.pop) begin
        rp_q[qidx_i]  <= rp_nxt;
        cnt_q[qidx_i] <= cnt_q[qidx_i] - 1'b1;
      end
      if (cmd_i.load_head) head_q[qidx_i] <= rdata[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      jt_q   <= req.job_time;
      tag_q  <= req.job_tag;
      best_q <= '0;
      tq_q   <= (req.cmd == CMD_PUSH_NAMED) ? req.queue_sel : '0;
    end else if (cmd_i.scan_step && scan_ld < limit_q && (!found_q || scan_ld <= best_q)) begin
      best_q <= scan_ld;
      tq_q   <= QSEL_W'(qidx_i);
    end
    if (cmd_i.push_do) begin
      out_kind_q   <= KIND_PUSH;
      out_status_q <= push_st;
      out_qi_q     <= tq_q;
      out_tag_q    <= '0;
      out_time_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.done_emit) begin
      out_kind_q   <= KIND_DONE;
      out_status_q <= ST_OK;
      out_qi_q     <= QSEL_W'(qidx_i);
      out_tag_q    <= rdata[ENTRY_W-1:TIME_W];
      out_time_q   <= rdata[TIME_W-1:0];
      out_last_q   <= !later;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.kind        = out_kind_q;
  assign rsp.status      = out_status_q;
  assign rsp.queue_index = out_qi_q;
  assign rsp.done_tag    = out_tag_q;
  assign rsp.done_time   = out_time_q;
  assign rsp.last        = out_last_q;

  assign sts_o.in_cmd   = req.cmd;
  assign sts_o.out_free = !out_valid_q || rsp.ready;
  assign sts_o.q_busy   = cnt_q[qidx_i] != '0;
  assign sts_o.q_done   = head_q[qidx_i] <= TIME_W'(1);
  assign sts_o.q_more   = cnt_q[qidx_i] != CW'(1);
endmodule

// ===== hdl/llq_chk.sv =====
`timescale 1ns / 1ps
module llq_chk import llq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [1:0]  out_status,
  input logic [15:0] out_tag,
  input logic [15:0] out_time,
  input logic        out_last
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_last))
    else $error("result dropped while stalled");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_PUSH |-> out_last && out_tag == '0 && out_time == '0)
    else $error("malformed push response");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_DONE |-> out_status == ST_OK)
    else $error("completion with nonzero status");
endmodule

bind least_loaded_job_queues llq_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .out_kind   (rsp_o.kind),
  .out_status (rsp_o.status),
  .out_tag    (rsp_o.done_tag),
  .out_time   (rsp_o.done_time),
  .out_last   (rsp_o.last)
);

// ===== bench/llq_checker.sv =====
`timescale 1ns / 1ps
module llq_checker import llq_pkg::*; #(
  parameter int NQ = 4,
  parameter int DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  llq_in_if.source          req_w,
  llq_out_if.sink           rsp_w,
  output int                fail_count_o,
  output int                pending_o
);
  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [2:0]  queue_index;
    logic [15:0] done_tag;
    logic [15:0] done_time;
    logic        last;
  } rsp_t;

  rsp_t        rsp_exp_q[$];
  logic [15:0] limit;
  logic [15:0] load[NQ];
  logic [15:0] head_left[NQ];
  logic [15:0] job_tags[NQ][$];
  logic [15:0] job_times[NQ][$];

  task automatic predict(input logic [1:0] cmd, input logic [2:0] sel,
                         input logic [15:0] jt, input logic [15:0] tg);
    logic found;
    int q;
    logic [15:0] best;
    status_e st;
    rsp_t r;
    int n;
    found = 0;
    q = 0;
    best = 0;
    n = 0;
    if (cmd == CMD_PUSH_LEAST || cmd == CMD_PUSH_NAMED) begin
      if (cmd == CMD_PUSH_NAMED) begin
        q = sel;
        found = sel < NQ;
      end else begin
        for (int i = 0; i < NQ; i++)
          if (load[i] < limit && (!found || load[i] <= best)) begin
            best = load[i];
            q = i;
            found = 1;
          end
      end
      if (!found) begin
        st = ST_NO_QUEUE;
        if (cmd == CMD_PUSH_LEAST) q = 0;
      end else if (17'(load[q]) + 17'(jt) >= 17'(limit)) st = ST_LIMIT;
      else if (job_tags[q].size() >= DEPTH) st = ST_FULL;
      else begin
        st = ST_OK;
        if (job_tags[q].size() == 0) head_left[q] = jt;
        job_tags[q].push_back(tg);
        job_times[q].push_back(jt);
        load[q] = load[q] + jt;
      end
      r = '{KIND_PUSH, st, 3'(q), 16'd0, 16'd0, 1'b1};
      rsp_exp_q.push_back(r);
    end else if (cmd == CMD_TICK) begin
      for (int a = 0; a < NQ; a++) begin
        if (job_tags[a].size() == 0) continue;
        if (head_left[a] != 0) begin
          head_left[a]--;
          if (load[a] != 0) load[a]--;
        end
        if (head_left[a] == 0) begin
          r = '{KIND_DONE, ST_OK, 3'(a), job_tags[a][0], job_times[a][0], 1'b0};
          rsp_exp_q.push_back(r);
          n++;
          void'(job_tags[a].pop_front());
          void'(job_times[a].pop_front());
          if (job_tags[a].size() != 0) head_left[a] = job_times[a][0];
        end
      end
      if (n > 0) rsp_exp_q[$].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    int nerr;
    nerr = 0;
    if (!rst_ni) begin
      limit = LIMIT_RESET;
      fail_count_o <= 0;
      rsp_exp_q.delete();
      for (int i = 0; i < NQ; i++) begin
        load[i] = 0;
        head_left[i] = 0;
        job_tags[i].delete();
        job_times[i].delete();
      end
    end else begin
      if (cfg_we_i) limit = cfg_wdata_i;
      if (rsp_w.valid && rsp_w.ready) begin
        if (rsp_exp_q.size() == 0) begin
          $error("unexpected transfer kind %0d", rsp_w.kind);
          nerr++;
        end else begin
          e = rsp_exp_q.pop_front();
          if (rsp_w.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, rsp_w.kind);
            nerr++;
          end
          if (rsp_w.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp_w.status);
            nerr++;
          end
          if (rsp_w.queue_index !== e.queue_index) begin
            $error("queue_index exp %0d got %0d", e.queue_index, rsp_w.queue_index);
            nerr++;
          end
          if (rsp_w.done_tag !== e.done_tag) begin
            $error("done_tag exp %0d got %0d", e.done_tag, rsp_w.done_tag);
            nerr++;
          end
          if (rsp_w.done_time !== e.done_time) begin
            $error("done_time exp %0d got %0d", e.done_time, rsp_w.done_time);
            nerr++;
          end
          if (rsp_w.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, rsp_w.last);
            nerr++;
          end
        end
      end
      if (nerr != 0) fail_count_o <= fail_count_o + nerr;
      if (req_w.valid && req_w.ready)
        predict(req_w.cmd, req_w.queue_sel, req_w.job_time, req_w.job_tag);
    end
    pending_o = rsp_exp_q.size();
  end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import llq_pkg::*;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic [TIME_W-1:0] cfg_wdata_i = 0;
  int                fail_count;
  int                pending;
  logic              calm = 0;
  int                rdy_gap;

  llq_in_if  req_w();
  llq_out_if rsp_w();

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  least_loaded_job_queues DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_w), .rsp_o(rsp_w)
  );

  llq_checker #(.NQ(NUM_QUEUES_DEF), .DEPTH(QUEUE_DEPTH_DEF)) chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_w(req_w), .rsp_w(rsp_w), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_w.ready <= 0;
      rdy_gap = 0;
    end else if (calm) rsp_w.ready <= 1;
    else if (rdy_gap > 0) begin
      rdy_gap--;
      rsp_w.ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      rdy_gap = $urandom_range(1, 17);
      rsp_w.ready <= 0;
    end else rsp_w.ready <= 1;
  end

  task automatic send_job(input logic [1:0] cmd, input logic [2:0] sel,
                          input logic [15:0] jt, input logic [15:0] tg);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_w.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_w.valid <= 1;
    req_w.cmd <= cmd;
    req_w.queue_sel <= sel;
    req_w.job_time <= jt;
    req_w.job_tag <= tg;
    do @(posedge clk_i); while (!req_w.ready);
  endtask

  task automatic drain_all;
    req_w.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [15:0] v);
    drain_all();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(input int n, input int tmax);
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9) < 4 ? CMD_TICK : 2'($urandom_range(0, 3));
      send_job(c, 3'($urandom), 16'($urandom_range(0, tmax)), 16'($urandom));
    end
  endtask

  initial begin
    req_w.valid = 0;
    req_w.cmd = 0;
    req_w.queue_sel = 0;
    req_w.job_time = 0;
    req_w.job_tag = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_job(CMD_PUSH_NAMED, 3'd0, 16'd1, 16'hFFFF);
    send_job(CMD_PUSH_NAMED, 3'd3, 16'd0, 16'h0000);
    send_job(CMD_PUSH_NAMED, 3'd7, 16'd5, 16'h1234);
    send_job(CMD_PUSH_NAMED, 3'd4, 16'd5, 16'h1234);
    send_job(CMD_PUSH_LEAST, 3'd0, 16'd999, 16'hAAAA);
    send_job(CMD_PUSH_LEAST, 3'd0, 16'hFFFF, 16'h5555);
    send_job(CMD_PUSH_LEAST, 3'd0, 16'd2, 16'h0001);
    send_job(2'd3, 3'd0, 16'd1, 16'd1);
    for (int i = 0; i < 9; i++) send_job(CMD_PUSH_NAMED, 3'd1, 16'd1, 16'(i));
    repeat (4) send_job(CMD_TICK, 3'd0, 16'd0, 16'd0);
    drain_all();
    random_phase(25, 300);
    set_limit(16'd0);
    send_job(CMD_PUSH_LEAST, 3'd0, 16'd1, 16'd7);
    send_job(CMD_PUSH_NAMED, 3'd2, 16'd0, 16'd7);
    set_limit(16'd1);
    send_job(CMD_PUSH_NAMED, 3'd2, 16'd0, 16'd9);
    send_job(CMD_PUSH_LEAST, 3'd0, 16'd0, 16'd9);
    random_phase(10, 2);
    set_limit(16'hFFFF);
    random_phase(20, 16'hFFFF);
    random_phase(10, 3);
    set_limit(16'd40);
    calm = 1;
    random_phase(15, 12);
    repeat (20) send_job(CMD_TICK, 3'd0, 16'd0, 16'd0);
    drain_all();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
